### sv/q16alu_pkg.sv
// ----------------------------------------------------------------------------
// q16alu_pkg
// Shared types and constants for the saturating Q16.16 fixed-point ALU.
// ----------------------------------------------------------------------------
package q16alu_pkg;

    localparam int FRACTION_BITS_DEFAULT = 16;

    localparam logic signed [31:0] SAT_POS_LIMIT = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_NEG_LIMIT = 32'sh8000_0000;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_ROUND = 3'd4,
        OP_CLAMP = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        KIND_SIMPLE = 2'd0,
        KIND_MUL    = 2'd1,
        KIND_DIV    = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] res;
    } item_t;

endpackage

### sv/q16_saturating_fixed_point_alu_core.sv
// ----------------------------------------------------------------------------
// q16_saturating_fixed_point_alu_core
// Path from accepted word to result word: queue, multiplier stage, one divide
// step per stage, output register. The divider is pipelined.
// Throughput: one word per cycle for every opcode while out_stall is low.
// Reset: rst_n clears the queue and all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
module q16_saturating_fixed_point_alu_core #(
    parameter int FRACTION_BITS = q16alu_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         op,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    input  logic signed [31:0] operand_c,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] result
);
    import q16alu_pkg::*;

    item_t front_item;
    item_t head_item;
    logic  q_full;
    logic  head_valid;
    logic  head_pop;

    assign in_stall = q_full;

    q16alu_front #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .op        (op),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .operand_c (operand_c),
        .item      (front_item)
    );

    q16alu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (in_valid),
        .wr_item   (front_item),
        .full      (q_full),
        .rd_en     (head_pop),
        .not_empty (head_valid),
        .rd_item   (head_item)
    );

    q16alu_back #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_pop   (head_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result)
    );

endmodule

### sv/q16alu_front.sv
// ----------------------------------------------------------------------------
// q16alu_front
// Decodes the opcode and finishes add, subtract, round and clamp; multiply
// and divide words are tagged for the back end.
// ----------------------------------------------------------------------------
module q16alu_front #(
    parameter int FRACTION_BITS = 16
) (
    input  logic [2:0]          op,
    input  logic signed [31:0]  operand_a,
    input  logic signed [31:0]  operand_b,
    input  logic signed [31:0]  operand_c,
    output q16alu_pkg::item_t   item
);
    import q16alu_pkg::*;

    localparam logic [32:0] HALF = 33'd1 << (FRACTION_BITS - 1);

    logic signed [32:0] sum;
    logic signed [32:0] diff;
    logic signed [31:0] sum_sat;
    logic signed [31:0] diff_sat;
    logic [31:0]        mag_a;
    logic [32:0]        rsum;
    logic [32:0]        rmag;
    logic signed [31:0] rnd;
    logic signed [31:0] clamp;

    always_comb
    begin
        sum   = {operand_a[31], operand_a} + {operand_b[31], operand_b};
        diff  = {operand_a[31], operand_a} - {operand_b[31], operand_b};
        sum_sat  = (sum[32] != sum[31]) ? (sum[32] ? SAT_NEG_LIMIT : SAT_POS_LIMIT)
                                        : sum[31:0];
        diff_sat = (diff[32] != diff[31]) ? (diff[32] ? SAT_NEG_LIMIT : SAT_POS_LIMIT)
                                          : diff[31:0];

        mag_a = operand_a[31] ? (32'd0 - operand_a) : operand_a;
        rsum  = {1'b0, mag_a} + HALF;
        rmag  = rsum >> FRACTION_BITS;
        rnd   = operand_a[31] ? (32'd0 - rmag[31:0]) : rmag[31:0];

        if (operand_b > operand_c)
        begin
            clamp = operand_b;
        end
        else if (operand_a < operand_b)
        begin
            clamp = operand_b;
        end
        else if (operand_a > operand_c)
        begin
            clamp = operand_c;
        end
        else
        begin
            clamp = operand_a;
        end
    end

    always_comb
    begin
        item.a    = operand_a;
        item.b    = operand_b;
        item.kind = KIND_SIMPLE;
        item.res  = '0;
        unique case (op_t'(op))
            OP_ADD:   item.res  = sum_sat;
            OP_SUB:   item.res  = diff_sat;
            OP_MUL:   item.kind = KIND_MUL;
            OP_DIV:   item.kind = KIND_DIV;
            OP_ROUND: item.res  = rnd;
            OP_CLAMP: item.res  = clamp;
            default:  item.res  = '0;
        endcase
    end

endmodule

### sv/q16alu_queue.sv
// ----------------------------------------------------------------------------
// q16alu_queue
// Two-entry queue between the front end and the execution pipeline.
// ----------------------------------------------------------------------------
module q16alu_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  q16alu_pkg::item_t wr_item,
    output logic              full,
    input  logic              rd_en,
    output logic              not_empty,
    output q16alu_pkg::item_t rd_item
);
    import q16alu_pkg::*;

    item_t      mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign rd_item   = mem[rd_ptr_reg];
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### sv/q16alu_back.sv
// ----------------------------------------------------------------------------
// q16alu_back
// Execution pipeline: multiplier stage, one restoring divide step per stage,
// saturation and the output register.
// ----------------------------------------------------------------------------
module q16alu_back #(
    parameter int FRACTION_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  q16alu_pkg::item_t  head_item,
    output logic               head_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] result
);
    import q16alu_pkg::*;

    localparam int NW = 32 + FRACTION_BITS;

    logic                adv;
    logic [NW:0]         vld_reg;
    kind_t               kind_reg [NW+1];
    logic signed [31:0]  res_reg  [NW+1];
    logic [NW-1:0]       nq_reg   [NW+1];
    logic [31:0]         rem_reg  [NW+1];
    logic [31:0]         d_reg    [NW+1];
    logic [NW:0]         neg_reg;
    logic [NW:0]         dz_reg;
    logic [NW:0]         an_reg;
    logic signed [63:0]  prod_reg;

    logic                out_valid_reg;
    logic signed [31:0]  result_reg;
    logic signed [31:0]  result_next;

    logic [31:0]         mag_a;
    logic [31:0]         mag_b;
    logic [63:0]         pmag;
    logic [63:0]         pshift;
    logic signed [31:0]  mul_res;
    logic [NW-1:0]       q;
    logic                q_big;

    assign adv       = !out_valid_reg || !out_stall;
    assign head_pop  = adv && head_valid;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        mag_a = head_item.a[31] ? (32'd0 - head_item.a) : head_item.a;
        mag_b = head_item.b[31] ? (32'd0 - head_item.b) : head_item.b;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_reg[0] <= head_item.kind;
            res_reg[0]  <= head_item.res;
            prod_reg    <= head_item.a * head_item.b;
            nq_reg[0]   <= {mag_a, {FRACTION_BITS{1'b0}}};
            rem_reg[0]  <= '0;
            d_reg[0]    <= mag_b;
            neg_reg[0]  <= head_item.a[31] ^ head_item.b[31];
            dz_reg[0]   <= (head_item.b == 32'sd0);
            an_reg[0]   <= head_item.a[31];
        end
    end

    always_comb
    begin
        pmag   = prod_reg[63] ? (64'd0 - prod_reg) : prod_reg;
        pshift = pmag >> FRACTION_BITS;
        if (prod_reg[63])
        begin
            mul_res = (pshift >= 64'h8000_0000) ? SAT_NEG_LIMIT : (32'd0 - pshift[31:0]);
        end
        else
        begin
            mul_res = (pshift > 64'h7FFF_FFFF) ? SAT_POS_LIMIT : pshift[31:0];
        end
    end

    for (genvar k = 1; k <= NW; k++)
    begin : g_step
        logic [32:0] rsh;
        logic [32:0] rdiff;
        logic        ge;

        always_comb
        begin
            rsh   = {rem_reg[k-1], nq_reg[k-1][NW-1]};
            rdiff = rsh - {1'b0, d_reg[k-1]};
            ge    = (rsh >= {1'b0, d_reg[k-1]});
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                kind_reg[k] <= kind_reg[k-1];
                if (k == 1 && kind_reg[k-1] == KIND_MUL)
                begin
                    res_reg[k] <= mul_res;
                end
                else
                begin
                    res_reg[k] <= res_reg[k-1];
                end
                nq_reg[k]  <= {nq_reg[k-1][NW-2:0], ge};
                rem_reg[k] <= ge ? rdiff[31:0] : rsh[31:0];
                d_reg[k]   <= d_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                dz_reg[k]  <= dz_reg[k-1];
                an_reg[k]  <= an_reg[k-1];
            end
        end
    end

    always_comb
    begin
        q     = nq_reg[NW];
        q_big = |q[NW-1:31];
        if (kind_reg[NW] != KIND_DIV)
        begin
            result_next = res_reg[NW];
        end
        else if (dz_reg[NW])
        begin
            result_next = an_reg[NW] ? SAT_NEG_LIMIT : SAT_POS_LIMIT;
        end
        else if (neg_reg[NW])
        begin
            result_next = q_big ? SAT_NEG_LIMIT : (32'd0 - q[31:0]);
        end
        else
        begin
            result_next = q_big ? SAT_POS_LIMIT : q[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[NW-1:0], head_valid};
            out_valid_reg <= vld_reg[NW];
        end
    end

endmodule

### test/tb_q16_saturating_fixed_point_alu_core.sv
// ----------------------------------------------------------------------------
// tb_q16_saturating_fixed_point_alu_core
// Drives opcode and operand words into the Q16.16 ALU and checks every result
// word, in order, against a local model of the saturating arithmetic.
// ----------------------------------------------------------------------------
module tb_q16_saturating_fixed_point_alu_core;
    timeunit 1ns;
    timeprecision 1ps;
    import q16alu_pkg::*;

    localparam int FB = FRACTION_BITS_DEFAULT;
    localparam int LATENCY = FB + 34;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         op;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic signed [31:0] operand_c;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] result;

    logic signed [31:0] expected_results[$];
    int                 error_count;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    bit                 hold_recv;

    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        bit                 known;
        logic signed [31:0] res;
    } vector_t;

    q16_saturating_fixed_point_alu_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .operand_c (operand_c),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [31:0] saturate(longint v);
        if (v > longint'(SAT_POS_LIMIT))
            return SAT_POS_LIMIT;
        if (v < longint'(SAT_NEG_LIMIT))
            return SAT_NEG_LIMIT;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] alu_value(logic [2:0] code, logic signed [31:0] a,
                                                     logic signed [31:0] b,
                                                     logic signed [31:0] c);
        longint sa;
        longint sb;
        longint sc;
        longint p;
        longint unsigned m;
        bit neg;
        sa = a;
        sb = b;
        sc = c;
        case (code)
            OP_ADD: return saturate(sa + sb);
            OP_SUB: return saturate(sa - sb);
            OP_MUL:
            begin
                p = sa * sb;
                neg = p < 0;
                m = neg ? -p : p;
                m = m >> FB;
                return saturate(neg ? -longint'(m) : longint'(m));
            end
            OP_DIV:
            begin
                if (sb == 0)
                    return sa >= 0 ? SAT_POS_LIMIT : SAT_NEG_LIMIT;
                neg = (sa < 0) != (sb < 0);
                m = (longint'(sa < 0 ? -sa : sa) << FB) / (sb < 0 ? -sb : sb);
                if (m > 64'd4294967296)
                    m = 64'd4294967296;
                return saturate(neg ? -longint'(m) : longint'(m));
            end
            OP_ROUND:
            begin
                m = ((sa < 0 ? -sa : sa) + (64'd1 << (FB - 1))) >> FB;
                return 32'(sa < 0 ? -longint'(m) : longint'(m));
            end
            OP_CLAMP:
            begin
                if (sb > sc || sa < sb)
                    return b;
                if (sa > sc)
                    return c;
                return a;
            end
            default: return '0;
        endcase
    endfunction

    function automatic logic signed [31:0] random_operand();
        case ($urandom_range(0, 7))
            0: return SAT_POS_LIMIT - $urandom_range(0, 3);
            1: return SAT_NEG_LIMIT + $urandom_range(0, 3);
            2: return $signed($urandom_range(0, 8)) - 4;
            3: return ($signed($urandom_range(0, 64)) - 32) <<< FB;
            4: return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
            5: return ($signed($urandom_range(0, 16)) - 8) * 32'sh8000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(logic [2:0] code, logic signed [31:0] a, logic signed [31:0] b,
                             logic signed [31:0] c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        op        <= code;
        operand_a <= a;
        operand_b <= b;
        operand_c <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(alu_value(code, a, b, c));
        @(negedge clk);
    endtask

    task automatic send_random(int count);
        logic [2:0] code;
        for (int i = 0; i < count; i++)
        begin
            code = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
            send_word(code, random_operand(), random_operand(), random_operand());
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        out_stall <= hold_recv || ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result: no word expected, actual %0d", result);
                error_count++;
            end
            else
            begin
                if (result !== expected_results[0])
                begin
                    $error("result: expected %0d, actual %0d", expected_results[0], result);
                    error_count++;
                end
                void'(expected_results.pop_front());
            end
        end
    end

    initial
    begin
        vector_t vectors[$];
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_ADD;
        operand_a = '0;
        operand_b = '0;
        operand_c = '0;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_recv = 1'b0;
        vectors = '{
            '{OP_ADD,   SAT_POS_LIMIT, 32'sd1, 32'sd0, 1, SAT_POS_LIMIT},
            '{OP_ADD,   SAT_NEG_LIMIT, -32'sd1, 32'sd0, 1, SAT_NEG_LIMIT},
            '{OP_ADD,   32'sh1_0000, 32'sh2_8000, 32'sd0, 0, 32'sd0},
            '{OP_SUB,   SAT_NEG_LIMIT, 32'sd1, 32'sd0, 1, SAT_NEG_LIMIT},
            '{OP_SUB,   SAT_POS_LIMIT, -32'sd1, 32'sd0, 1, SAT_POS_LIMIT},
            '{OP_SUB,   32'sd5, 32'sd9, 32'sd0, 0, 32'sd0},
            '{OP_MUL,   SAT_POS_LIMIT, SAT_POS_LIMIT, 32'sd0, 1, SAT_POS_LIMIT},
            '{OP_MUL,   SAT_NEG_LIMIT, SAT_POS_LIMIT, 32'sd0, 1, SAT_NEG_LIMIT},
            '{OP_MUL,   SAT_NEG_LIMIT, SAT_NEG_LIMIT, 32'sd0, 1, SAT_POS_LIMIT},
            '{OP_MUL,   -32'sd1, 32'sd1, 32'sd0, 1, 32'sd0},
            '{OP_MUL,   -32'sh1_8000, 32'sh2_0001, 32'sd0, 0, 32'sd0},
            '{OP_DIV,   32'sd7, 32'sd0, 32'sd0, 1, SAT_POS_LIMIT},
            '{OP_DIV,   32'sd0, 32'sd0, 32'sd0, 1, SAT_POS_LIMIT},
            '{OP_DIV,   -32'sd7, 32'sd0, 32'sd0, 1, SAT_NEG_LIMIT},
            '{OP_DIV,   SAT_NEG_LIMIT, 32'sd1, 32'sd0, 1, SAT_NEG_LIMIT},
            '{OP_DIV,   SAT_NEG_LIMIT, -32'sd1, 32'sd0, 1, SAT_POS_LIMIT},
            '{OP_DIV,   -32'sh1_0000, 32'sh3_0000, 32'sd0, 0, 32'sd0},
            '{OP_ROUND, 32'sh0_8000, 32'sd0, 32'sd0, 1, 32'sd1},
            '{OP_ROUND, -32'sh0_8000, 32'sd0, 32'sd0, 1, -32'sd1},
            '{OP_ROUND, SAT_POS_LIMIT, 32'sd0, 32'sd0, 1, 32'sd32768},
            '{OP_ROUND, SAT_NEG_LIMIT, 32'sd0, 32'sd0, 1, -32'sd32768},
            '{OP_CLAMP, 32'sd0, 32'sd10, 32'sd5, 1, 32'sd10},
            '{OP_CLAMP, SAT_NEG_LIMIT, -32'sd3, 32'sd3, 1, -32'sd3},
            '{OP_CLAMP, SAT_POS_LIMIT, -32'sd3, 32'sd3, 1, 32'sd3},
            '{3'd7, -32'sd1, -32'sd1, -32'sd1, 1, 32'sd0}
        };
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (vectors[i])
        begin
            if (vectors[i].known && alu_value(vectors[i].op, vectors[i].a, vectors[i].b,
                                              vectors[i].c) !== vectors[i].res)
            begin
                $error("model: expected %0d, actual %0d", vectors[i].res,
                       alu_value(vectors[i].op, vectors[i].a, vectors[i].b, vectors[i].c));
                error_count++;
            end
            send_word(vectors[i].op, vectors[i].a, vectors[i].b, vectors[i].c);
        end

        send_random(300);
        send_idle_pct = 77;
        send_random(250);
        send_idle_pct = 0;
        recv_stall_pct = 77;
        send_random(250);
        send_idle_pct = 32;
        recv_stall_pct = 32;
        send_random(250);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            send_random(200);
            begin
                hold_recv = 1'b1;
                repeat (300) @(negedge clk);
                hold_recv = 1'b0;
            end
        join
        send_random(100);
        drain();
        repeat (LATENCY + 10) @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

### q16_saturating_fixed_point_alu_core.f
sv/q16alu_pkg.sv
sv/q16alu_front.sv
sv/q16alu_queue.sv
sv/q16alu_back.sv
sv/q16_saturating_fixed_point_alu_core.sv
test/tb_q16_saturating_fixed_point_alu_core.sv
